/* hw/rtl/sbfd_pkg.sv */
// Shared types and constants of the SBUS frame decoder.
// Used by every module of the decoder; depends on nothing.
package sbfd_pkg;

  localparam int unsigned DataBytes = 22;
  localparam int unsigned NumCh     = 16;
  localparam int unsigned ChBits    = 11;
  localparam int unsigned FrameBits = DataBytes * 8;
  localparam int unsigned CntW      = $clog2(DataBytes);
  localparam int unsigned ChIdxW    = $clog2(NumCh);
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [CntW-1:0]   LastDataCnt = CntW'(DataBytes - 1);
  localparam logic [ChIdxW-1:0] LastCh      = ChIdxW'(NumCh - 1);

  // Register reset values.
  localparam logic [7:0] HeaderRst   = 8'h0F;
  localparam logic [7:0] FooterRst   = 8'h00;
  localparam logic [7:0] LostRst     = 8'h04;
  localparam logic [7:0] FailsafeRst = 8'h08;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER   = 8'd0,
    CFG_FOOTER   = 8'd1,
    CFG_LOST     = 8'd2,
    CFG_FAILSAFE = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_FLAGS  = 4'b0100,
    PH_FOOTER = 4'b1000
  } phase_e;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;
  } cfg_wr_t;

  // One good frame handed from the parser to the unpacker.
  typedef struct packed {
    logic                 lost;
    logic                 failsafe;
    logic [FrameBits-1:0] data;
  } frame_t;

endpackage

/* hw/rtl/sbfd_front.sv */
// Byte parser of the SBUS frame decoder: header hunt, payload capture, footer check.
// Depends on sbfd_pkg.
module sbfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbfd_pkg::cfg_wr_t cfg_i,
  input  logic             byte_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             footer_phase_o,
  output logic             frame_push_o,
  output sbfd_pkg::frame_t frame_o
);
  import sbfd_pkg::*;

  logic [7:0] header_q, footer_q, lost_mask_q, failsafe_mask_q;
  phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0] flags_q;
  logic [FrameBits-1:0] data_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q        <= HeaderRst;
      footer_q        <= FooterRst;
      lost_mask_q     <= LostRst;
      failsafe_mask_q <= FailsafeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_HEADER:   header_q        <= cfg_i.data;
        CFG_FOOTER:   footer_q        <= cfg_i.data;
        CFG_LOST:     lost_mask_q     <= cfg_i.data;
        CFG_FAILSAFE: failsafe_mask_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (rx_byte_i == header_q) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == LastDataCnt) begin
            phase_d = PH_FLAGS;
          end
        end
        PH_FLAGS:  phase_d = PH_FOOTER;
        PH_FOOTER: phase_d = PH_HEADER;
        default:   phase_d = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (byte_valid_i && phase_q == PH_FLAGS) begin
        flags_q <= rx_byte_i;
      end
    end
  end

  // Shift payload bytes in from the top; byte 0 ends up in the low bits.
  always_ff @(posedge clk_i) begin
    if (byte_valid_i && phase_q == PH_DATA) begin
      data_q <= {rx_byte_i, data_q[FrameBits-1:8]};
    end
  end

  assign footer_phase_o = (phase_q == PH_FOOTER);
  assign frame_push_o   = byte_valid_i && footer_phase_o && (rx_byte_i == footer_q);
  assign frame_o.lost     = |(flags_q & lost_mask_q);
  assign frame_o.failsafe = |(flags_q & failsafe_mask_q);
  assign frame_o.data     = data_q;

endmodule

/* hw/rtl/sbfd_frame_fifo.sv */
// Short queue of decoded frames between the parser and the unpacker.
// Depends on sbfd_pkg.
module sbfd_frame_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbfd_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output sbfd_pkg::frame_t data_o,
  output logic             empty_o
);
  import sbfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("frame queue read while empty");

endmodule

/* hw/rtl/sbfd_back.sv */
// Channel unpacker of the SBUS frame decoder with its output register.
// Depends on sbfd_pkg.
module sbfd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbfd_pkg::frame_t           frame_i,
  input  logic                       frame_empty_i,
  output logic                       frame_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [sbfd_pkg::ChIdxW-1:0] channel_index_o,
  output logic [sbfd_pkg::ChBits-1:0] channel_value_o,
  output logic                       frame_lost_o,
  output logic                       failsafe_o,
  output logic                       last_channel_o
);
  import sbfd_pkg::*;

  logic busy_q;
  logic [ChIdxW-1:0] ch_q;
  logic [FrameBits-1:0] data_q;
  logic lost_q, fs_q;
  logic out_valid_q;
  logic out_adv, ch_done;

  assign out_adv     = !out_valid_q || pop_i;
  assign ch_done     = busy_q && out_adv && (ch_q == LastCh);
  assign frame_pop_o = !frame_empty_i && (!busy_q || ch_done);
  assign empty_o     = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= busy_q;
      end
      if (frame_pop_o) begin
        busy_q <= 1'b1;
        ch_q   <= '0;
      end else if (busy_q && out_adv) begin
        ch_q <= ch_q + ChIdxW'(1);
        if (ch_done) busy_q <= 1'b0;
      end
    end
  end

  // Channel k sits in the low bits after k shifts of one channel width.
  always_ff @(posedge clk_i) begin
    if (frame_pop_o) begin
      data_q <= frame_i.data;
      lost_q <= frame_i.lost;
      fs_q   <= frame_i.failsafe;
    end else if (busy_q && out_adv) begin
      data_q <= {{ChBits{1'b0}}, data_q[FrameBits-1:ChBits]};
    end
    if (busy_q && out_adv) begin
      channel_index_o <= ch_q;
      channel_value_o <= data_q[ChBits-1:0];
      frame_lost_o    <= lost_q;
      failsafe_o      <= fs_q;
      last_channel_o  <= (ch_q == LastCh);
    end
  end

  a_idle_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ch_q == '0)
    else $error("channel counter not parked while idle");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_adv && ch_q == LastCh) |=> (out_valid_q && last_channel_o))
    else $error("final channel not marked last");

endmodule

/* hw/rtl/sbus_frame_decoder_top.sv */
// SBUS frame decoder: one received byte per cycle in, 16 channel results per good frame out.
// A footer byte goes into the frame queue, its frame into the unpacker, channel 0 into the output register.
// Throughput: one byte and one result per cycle; a frame's 16 results drain while the
// next 25 bytes arrive, and full rises only on a footer byte with FrameQDepth frames queued.
// Reset: rst_ni clears the parser, queue and unpacker and restores the register defaults;
// no clearing pass, the block takes bytes right after reset. Depends on sbfd_pkg and submodules.
module sbus_frame_decoder_top #(
  parameter int unsigned FrameQDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input queue side
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte_i,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sbfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output logic [sbfd_pkg::ChIdxW-1:0]  channel_index_o,
  output logic [sbfd_pkg::ChBits-1:0]  channel_value_o,
  output logic                        frame_lost_o,
  output logic                        failsafe_o,
  output logic                        last_channel_o
);
  import sbfd_pkg::*;

  cfg_wr_t cfg_wr;
  frame_t  front_frame, back_frame;
  logic    byte_accept;
  logic    footer_phase;
  logic    frame_push, frame_pop;
  logic    frame_full, frame_empty;

  // Registers are plain flops; accept every write transaction.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Stall only the footer byte, and only when the frame queue has no room for it.
  assign full        = footer_phase && frame_full;
  assign byte_accept = push && !full;

  sbfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_wr),
    .byte_valid_i   (byte_accept),
    .rx_byte_i      (rx_byte_i),
    .footer_phase_o (footer_phase),
    .frame_push_o   (frame_push),
    .frame_o        (front_frame)
  );

  // Decouple the parser from the unpacker so each side stalls on its own.
  sbfd_frame_fifo #(
    .Depth (FrameQDepth)
  ) u_frame_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .data_i  (front_frame),
    .full_o  (frame_full),
    .pop_i   (frame_pop),
    .data_o  (back_frame),
    .empty_o (frame_empty)
  );

  // Unpack one channel per cycle into the output register; advance on pop.
  sbfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_i         (back_frame),
    .frame_empty_i   (frame_empty),
    .frame_pop_o     (frame_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_lost_o    (frame_lost_o),
    .failsafe_o      (failsafe_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

/* tb/tb_sbus_frame_decoder_top.sv */
// Self-checking testbench for sbus_frame_decoder_top: byte stream in, channel results out.
// Depends on sbfd_pkg and the decoder RTL; a built-in frame predictor supplies expectations.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder_top;
  import sbfd_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RST_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES = 16;      // well past the footer-to-result latency
  localparam int unsigned HOLD_CYCLES  = 350;      // long pop hold-off in the first phase
  localparam int unsigned PRESS_FRAMES = 4;        // good frames sent behind the hold-off
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_PHASES   = 4;

  // Index beyond the register file; the write must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 8'hFF;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,       // expectations come from the predictor
    CHK_NONE,        // no result may appear
    CHK_FULL_SCALE   // 16 channels at 2047 with both flags set
  } chk_e;

  typedef struct packed {
    logic [4:0] reps;
    logic [7:0] val;
    chk_e       chk;
  } seg_t;

  typedef struct packed {
    logic [ChIdxW-1:0] idx;
    logic [ChBits-1:0] val;
    logic              lost;
    logic              fs;
    logic              last;
  } chan_res_t;

  // DUT signals
  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          rx_byte_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [7:0]          cfg_data_i;
  logic                empty;
  logic                pop;
  logic [ChIdxW-1:0]   channel_index_o;
  logic [ChBits-1:0]   channel_value_o;
  logic                frame_lost_o;
  logic                failsafe_o;
  logic                last_channel_o;

  // Predictor state: parser phase, stored frame bytes and register copies.
  phase_e              prs_phase;
  int unsigned         prs_count;
  logic [7:0]          prs_store [DataBytes];
  logic [7:0]          prs_flags;
  logic [7:0]          hdr_reg;
  logic [7:0]          ftr_reg;
  logic [7:0]          lost_reg;
  logic [7:0]          fs_reg;

  chan_res_t           chan_expect_q [$];
  int unsigned         err_cnt;
  int unsigned         cycle_cnt;
  int unsigned         bytes_sent;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  logic                hold_go;
  logic                hold_pop;

  seg_t                dir_tab [10];

  sbus_frame_decoder_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_lost_o    (frame_lost_o),
    .failsafe_o      (failsafe_o),
    .last_channel_o  (last_channel_o)
  );

  // Free-running clock, 12 ns period.
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_decoder_model();
    prs_phase = PH_HEADER;
    prs_count = 0;
    prs_flags = 8'h00;
    for (int i = 0; i < DataBytes; i++) prs_store[i] = 8'h00;
    hdr_reg  = HeaderRst;
    ftr_reg  = FooterRst;
    lost_reg = LostRst;
    fs_reg   = FailsafeRst;
  endfunction

  // Advance the parser by one accepted byte; on a good footer, queue the
  // 16 decoded channels when enq is set.
  function automatic void decode_byte(input logic [7:0] b, input bit enq);
    logic [FrameBits-1:0] frame_bits;
    chan_res_t            res;
    case (prs_phase)
      PH_HEADER: begin
        if (b == hdr_reg) begin
          prs_count = 0;
          prs_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        prs_store[prs_count] = b;
        prs_count++;
        if (prs_count >= DataBytes) prs_phase = PH_FLAGS;
      end
      PH_FLAGS: begin
        prs_flags = b;
        prs_phase = PH_FOOTER;
      end
      default: begin
        if (b == ftr_reg && enq) begin
          // The 22 bytes form one little-endian bit stream, 11 bits per channel.
          for (int i = 0; i < DataBytes; i++) frame_bits[8*i +: 8] = prs_store[i];
          for (int k = 0; k < NumCh; k++) begin
            res.idx  = ChIdxW'(k);
            res.val  = frame_bits[ChBits*k +: ChBits];
            res.lost = |(prs_flags & lost_reg);
            res.fs   = |(prs_flags & fs_reg);
            res.last = (k == NumCh - 1);
            chan_expect_q.push_back(res);
          end
        end
        // Any footer, good or bad, closes the frame and clears its contents.
        prs_phase = PH_HEADER;
        prs_count = 0;
        prs_flags = 8'h00;
        for (int i = 0; i < DataBytes; i++) prs_store[i] = 8'h00;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
  endtask

  task automatic check_channel();
    chan_res_t want;
    if (chan_expect_q.size() == 0) begin
      report_mismatch("unexpected result, channel_index", int'(channel_index_o), -1);
    end else begin
      want = chan_expect_q.pop_front();
      if (channel_index_o !== want.idx)
        report_mismatch("channel_index", int'(channel_index_o), int'(want.idx));
      if (channel_value_o !== want.val)
        report_mismatch("channel_value", int'(channel_value_o), int'(want.val));
      if (frame_lost_o !== want.lost)
        report_mismatch("frame_lost", int'(frame_lost_o), int'(want.lost));
      if (failsafe_o !== want.fs)
        report_mismatch("failsafe", int'(failsafe_o), int'(want.fs));
      if (last_channel_o !== want.last)
        report_mismatch("last_channel", int'(last_channel_o), int'(want.last));
    end
  endtask

  // Result side: drive pop at the falling edge, take a transaction at the
  // rising edge. The hold-off overrides the random stall.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= !hold_pop && ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_channel();
    end
  end

  // Long pop hold-off, counted here so the sender keeps offering bytes and
  // the frame queue fills until full stalls the input.
  initial begin
    hold_pop = 1'b0;
    wait (hold_go);
    hold_pop = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_pop = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one byte; hold it until a transaction completes, then advance the
  // predictor. push is left high so back-to-back bytes never drop it.
  task automatic send_byte(input logic [7:0] b, input chk_e chk);
    chan_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    decode_byte(b, chk == CHK_MODEL);
    if (chk == CHK_FULL_SCALE) begin
      for (int k = 0; k < NumCh; k++) begin
        res = '{idx: ChIdxW'(k), val: 11'h7FF, lost: 1'b1, fs: 1'b1, last: (k == NumCh - 1)};
        chan_expect_q.push_back(res);
      end
    end
  endtask

  // Drop push, wait for every expected channel, then let the pipeline settle.
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (chan_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write transaction; the predictor copy follows the index.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HEADER:   hdr_reg  = val;
      CFG_FOOTER:   ftr_reg  = val;
      CFG_LOST:     lost_reg = val;
      CFG_FAILSAFE: fs_reg   = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest is line noise
  // and truncated frames that knock the parser out of step.
  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned fill;
    logic [7:0]  b;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        send_byte(hdr_reg, CHK_MODEL);
        fill = $urandom_range(3);
        for (int i = 0; i < DataBytes; i++) begin
          case (fill)
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(255));
          endcase
          send_byte(b, CHK_MODEL);
        end
        if ($urandom_range(3) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
        else b = 8'($urandom_range(255));
        send_byte(b, CHK_MODEL);
        // Corrupt roughly one footer in five.
        if ($urandom_range(4) == 0) b = ftr_reg ^ 8'($urandom_range(1, 255));
        else b = ftr_reg;
        send_byte(b, CHK_MODEL);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), CHK_MODEL);
      end else begin
        send_byte(hdr_reg, CHK_MODEL);
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(255)), CHK_MODEL);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [7:0]  phase_cfg [NUM_PHASES][4];
    int unsigned phase_items [NUM_PHASES];
    int unsigned phase_send [NUM_PHASES];
    int unsigned phase_recv [NUM_PHASES];

    // Drive every input to a known value from time zero.
    rst_ni         = 1'b0;
    push           = 1'b0;
    rx_byte_i      = 8'h00;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_HEADER;
    cfg_data_i     = 8'h00;
    hold_go        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_cnt        = 0;
    bytes_sent     = 0;
    reset_decoder_model();

    // Directed walk at reset register values.
    dir_tab = '{
      '{5'd1,  8'h00,     CHK_MODEL},       // noise while waiting for the header
      '{5'd1,  8'hFF,     CHK_MODEL},
      '{5'd1,  HeaderRst, CHK_MODEL},
      '{5'd22, 8'hFF,     CHK_MODEL},       // every channel at full scale
      '{5'd1,  8'hFF,     CHK_MODEL},       // flags with every bit set
      '{5'd1,  FooterRst, CHK_FULL_SCALE},  // good footer
      '{5'd1,  HeaderRst, CHK_MODEL},
      '{5'd22, HeaderRst, CHK_MODEL},       // header value inside a frame is plain data
      '{5'd1,  HeaderRst, CHK_MODEL},       // ... and plain flags
      '{5'd1,  8'h5A,     CHK_NONE}         // bad footer drops the frame
    };

    // Register settings per random phase, extremes among them. The second
    // one makes header and footer equal, so a footer must not restart a frame.
    phase_cfg = '{
      '{HeaderRst, FooterRst, LostRst, FailsafeRst},
      '{8'hFF, 8'hFF, 8'hFF, 8'h00},
      '{8'h00, 8'hFF, 8'h00, 8'hFF},
      '{8'hA5, 8'h5A, 8'h81, 8'h7E}
    };
    phase_items = '{10, 25, 25, 25};
    phase_send  = '{0, 68, 0, 37};
    phase_recv  = '{0, 0, 68, 37};

    // Single reset pulse, released on a falling edge.
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // An out-of-range index must leave every register untouched.
    write_reg(CFG_UNUSED, 8'hFF);

    foreach (dir_tab[r]) begin
      repeat (dir_tab[r].reps) send_byte(dir_tab[r].val, dir_tab[r].chk);
    end
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_HEADER,   phase_cfg[ph][0]);
      write_reg(CFG_FOOTER,   phase_cfg[ph][1]);
      write_reg(CFG_LOST,     phase_cfg[ph][2]);
      write_reg(CFG_FAILSAFE, phase_cfg[ph][3]);
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      // Start the pop hold-off with the first back-to-back phase, and push
      // enough good frames behind it to fill the frame queue and stall input.
      if (ph == 0) begin
        hold_go = 1'b1;
        repeat (PRESS_FRAMES) begin
          send_byte(hdr_reg, CHK_MODEL);
          repeat (DataBytes) send_byte(8'($urandom_range(255)), CHK_MODEL);
          send_byte(8'($urandom_range(255)), CHK_MODEL);
          send_byte(ftr_reg, CHK_MODEL);
        end
      end
      run_random(phase_items[ph]);
      drain_results();
    end

    if (err_cnt == 0 && chan_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
